// ===== rtl/core/trie_insert_and_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Trie assertion macros
// Shared property templates for the trie insert and lookup block.
// ----------------------------------------------------------------------------
`ifndef TRIE_INSERT_AND_LOOKUP_ASSERT_SVH
`define TRIE_INSERT_AND_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TRIE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRIE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/trie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie package
// Shared constants, operation codes and controller states.
// ----------------------------------------------------------------------------
package trie_pkg;

  localparam int NODE_COUNT_DEF    = 256;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int OP_W              = 2;
  localparam int LETTER_W          = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_WORD   = 2'd1,
    OP_PREFIX = 2'd2
  } trie_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MARK
  } trie_state_t;

endpackage

// ===== rtl/core/trie_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie RAM
// Simple dual-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module trie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/trie_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie controller
// Walks the child table one letter per transfer, allocates nodes on insert,
// sets and tests end-of-word marks, and runs the clearing pass after reset.
// ----------------------------------------------------------------------------
`include "trie_insert_and_lookup_assert.svh"

module trie_ctrl import trie_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  localparam int CDEPTH  = NODE_COUNT * ALPHABET_SIZE,
  localparam int CADDR_W = $clog2(CDEPTH),
  localparam int NODE_W  = $clog2(NODE_COUNT),
  localparam int USED_W  = $clog2(NODE_COUNT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_letter,
  output logic                done,
  output logic                found,
  output logic                pool_exhausted,
  output logic                child_we,
  output logic [CADDR_W-1:0]  child_waddr,
  output logic [NODE_W-1:0]   child_wdata,
  output logic                child_re,
  output logic [CADDR_W-1:0]  child_raddr,
  input  logic [NODE_W-1:0]   child_rdata,
  output logic                mark_we,
  output logic [NODE_W-1:0]   mark_waddr,
  output logic                mark_wdata,
  output logic                mark_re,
  output logic [NODE_W-1:0]   mark_raddr,
  input  logic                mark_rdata
);

  trie_state_t         state, state_next;
  logic [CADDR_W-1:0]  clr_cnt, clr_cnt_next;
  logic [NODE_W-1:0]   cur_node, cur_node_next;
  logic [USED_W-1:0]   nodes_used, nodes_used_next;
  logic                path_missing, path_missing_next;
  logic                overflowed, overflowed_next;
  logic [OP_W-1:0]     op_q, op_q_next;
  logic                last_q, last_q_next;
  logic                walk_q, walk_q_next;
  logic [CADDR_W-1:0]  caddr_q, caddr_q_next;
  logic                done_next, found_next, pool_exhausted_next;
  logic                walking, letter_ok, intact;
  logic [CADDR_W-1:0]  caddr_in;

  assign busy      = (state != ST_IDLE);
  assign walking   = !path_missing && !overflowed;
  assign letter_ok = (int'(letter) < ALPHABET_SIZE);
  assign intact    = !path_missing && !overflowed;
  assign caddr_in  = CADDR_W'(CADDR_W'(cur_node) * CADDR_W'(ALPHABET_SIZE)
                              + CADDR_W'(letter));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CADDR_W'(CDEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = last_q ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    clr_cnt_next        = clr_cnt;
    cur_node_next       = cur_node;
    nodes_used_next     = nodes_used;
    path_missing_next   = path_missing;
    overflowed_next     = overflowed;
    op_q_next           = op_q;
    last_q_next         = last_q;
    walk_q_next         = walk_q;
    caddr_q_next        = caddr_q;
    done_next           = 1'b0;
    found_next          = found;
    pool_exhausted_next = pool_exhausted;
    child_we            = 1'b0;
    child_waddr         = caddr_q;
    child_wdata         = '0;
    child_re            = 1'b0;
    child_raddr         = caddr_in;
    mark_we             = 1'b0;
    mark_waddr          = cur_node;
    mark_wdata          = 1'b0;
    mark_re             = 1'b0;
    mark_raddr          = cur_node;
    unique case (state)
      ST_CLEAR: begin
        child_we     = 1'b1;
        child_waddr  = clr_cnt;
        mark_we      = (clr_cnt < CADDR_W'(NODE_COUNT));
        mark_waddr   = clr_cnt[NODE_W-1:0];
        clr_cnt_next = clr_cnt + CADDR_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_q_next    = op;
          last_q_next  = last_letter;
          walk_q_next  = walking && letter_ok;
          caddr_q_next = caddr_in;
          child_re     = walking && letter_ok;
          if (walking && !letter_ok) begin
            path_missing_next = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (walk_q) begin
          if (child_rdata != '0) begin
            cur_node_next = child_rdata;
          end else if (op_q != OP_INSERT) begin
            path_missing_next = 1'b1;
          end else if (nodes_used >= USED_W'(NODE_COUNT)) begin
            overflowed_next = 1'b1;
          end else begin
            child_we        = 1'b1;
            child_wdata     = nodes_used[NODE_W-1:0];
            cur_node_next   = nodes_used[NODE_W-1:0];
            nodes_used_next = nodes_used + USED_W'(1);
          end
        end
        mark_re    = last_q;
        mark_raddr = cur_node_next;
      end
      ST_MARK: begin
        done_next           = 1'b1;
        pool_exhausted_next = overflowed;
        if (op_q == OP_INSERT) begin
          found_next = intact;
          mark_we    = intact;
          mark_wdata = 1'b1;
        end else if (op_q == OP_WORD) begin
          found_next = intact && mark_rdata;
        end else begin
          found_next = intact;
        end
        cur_node_next     = '0;
        path_missing_next = 1'b0;
        overflowed_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      cur_node     <= '0;
      nodes_used   <= USED_W'(1);
      path_missing <= 1'b0;
      overflowed   <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      cur_node     <= cur_node_next;
      nodes_used   <= nodes_used_next;
      path_missing <= path_missing_next;
      overflowed   <= overflowed_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q           <= op_q_next;
    last_q         <= last_q_next;
    walk_q         <= walk_q_next;
    caddr_q        <= caddr_q_next;
    found          <= found_next;
    pool_exhausted <= pool_exhausted_next;
  end

  `TRIE_ASSERT_NXT(a_mark_gives_result, clk, rst, state == ST_MARK, done,
    "final letter did not produce a result")
  `TRIE_ASSERT_NXT(a_mid_letter_returns, clk, rst, state == ST_READ && !last_q,
    state == ST_IDLE && !done, "inner letter did not return to idle silently")
  `TRIE_ASSERT_IMP(a_pool_bounds, clk, rst, 1'b1,
    nodes_used != '0 && nodes_used <= USED_W'(NODE_COUNT),
    "node count out of bounds")
  `TRIE_ASSERT_IMP(a_walk_in_pool, clk, rst, state == ST_IDLE,
    USED_W'(cur_node) < nodes_used, "walk points at an unallocated node")
  `TRIE_ASSERT_IMP(a_link_nonzero, clk, rst, state == ST_READ && child_we,
    child_wdata != '0, "new link points at the root")
  `TRIE_ASSERT_IMP(a_abort_not_found, clk, rst, done && pool_exhausted, !found,
    "aborted insert reported as stored")

endmodule

// ===== rtl/core/trie_insert_and_lookup.sv =====
`timescale 1ns / 1ps
// Each letter transfer occupies the block: the accept cycle issues the
// child-table read, the next cycle resolves the link or allocates a node.
// A final letter then passes through the end-mark state for the mark read or write; done pulses the cycle after.
// A new letter is taken only in idle, once the previous letter has left the read and mark states.
// After reset, busy stays high while the child table and end marks are swept to
// zero; results are never stalled.
// ----------------------------------------------------------------------------
// Trie insert and lookup
// Letter-serial trie over a fixed node pool held in synchronous memories.
// ----------------------------------------------------------------------------
module trie_insert_and_lookup import trie_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_letter,
  output logic                done,
  output logic                found,
  output logic                pool_exhausted
);

  localparam int CDEPTH  = NODE_COUNT * ALPHABET_SIZE;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int NODE_W  = $clog2(NODE_COUNT);

  logic               child_we, child_re;
  logic [CADDR_W-1:0] child_waddr, child_raddr;
  logic [NODE_W-1:0]  child_wdata, child_rdata;
  logic               mark_we, mark_re, mark_wdata, mark_rdata;
  logic [NODE_W-1:0]  mark_waddr, mark_raddr;

  trie_ctrl #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .letter         (letter),
    .last_letter    (last_letter),
    .done           (done),
    .found          (found),
    .pool_exhausted (pool_exhausted),
    .child_we       (child_we),
    .child_waddr    (child_waddr),
    .child_wdata    (child_wdata),
    .child_re       (child_re),
    .child_raddr    (child_raddr),
    .child_rdata    (child_rdata),
    .mark_we        (mark_we),
    .mark_waddr     (mark_waddr),
    .mark_wdata     (mark_wdata),
    .mark_re        (mark_re),
    .mark_raddr     (mark_raddr),
    .mark_rdata     (mark_rdata)
  );

  trie_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CDEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  trie_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert and lookup testbench
// Streams words letter by letter into the trie: a short directed set, then
// random words over a small alphabet, long inserts that use up the node
// pool, and a mixed tail. A local trie model predicts every result, and the
// results are checked in order as the done strobe marks them.
// ----------------------------------------------------------------------------
module tb import trie_pkg::*; ();

  localparam int NODES = NODE_COUNT_DEF;
  localparam int LETTERS = ALPHABET_SIZE_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int SAVED_MAX = 64;
  localparam int WORD_MAX = 12;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                drain;
  } letter_item_t;

  typedef struct packed {
    logic found;
    logic exhausted;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OP_W-1:0]     op = '0;
  logic [LETTER_W-1:0] letter = '0;
  logic                last_letter = 1'b0;
  logic                busy;
  logic                done;
  logic                found;
  logic                pool_exhausted;

  letter_item_t   pending_items[$];
  lookup_result_t expected_lookups[$];
  letter_item_t   cur_item;
  logic           next_start;
  int             idle_left;
  bit             calm;
  int             mismatches = 0;
  int             item_count = 0;

  // Local copy of the trie.
  logic [7:0] link_mem [NODES*LETTERS];
  logic       word_end [NODES];
  int         alloc_count;
  int         walk_node;
  bit         walk_broken;
  bit         walk_overflow;

  // Words already inserted, replayed later as queries and repeat inserts.
  logic [LETTER_W-1:0] word_buf [WORD_MAX];
  logic [LETTER_W-1:0] saved_letters [SAVED_MAX*WORD_MAX];
  int                  saved_len [SAVED_MAX];
  int                  saved_count = 0;

  trie_insert_and_lookup DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .letter(letter),
    .last_letter(last_letter),
    .done(done),
    .found(found),
    .pool_exhausted(pool_exhausted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic trie_clear();
    for (int i = 0; i < NODES*LETTERS; i++) link_mem[i] = '0;
    for (int i = 0; i < NODES; i++) word_end[i] = 1'b0;
    alloc_count = 1;
    walk_node = 0;
    walk_broken = 0;
    walk_overflow = 0;
  endtask

  task automatic trie_predict_step(input letter_item_t it);
    int slot;
    int nxt;
    bit intact;
    lookup_result_t res;
    if (!walk_broken && !walk_overflow) begin
      if (int'(it.letter) >= LETTERS) begin
        walk_broken = 1;
      end else begin
        slot = walk_node * LETTERS + int'(it.letter);
        nxt = int'(link_mem[slot]);
        if (nxt != 0) begin
          walk_node = nxt;
        end else if (it.op != OP_INSERT) begin
          walk_broken = 1;
        end else if (alloc_count >= NODES) begin
          walk_overflow = 1;
        end else begin
          link_mem[slot] = alloc_count[7:0];
          walk_node = alloc_count;
          alloc_count = alloc_count + 1;
        end
      end
    end
    if (it.last) begin
      intact = !walk_broken && !walk_overflow;
      if (it.op == OP_INSERT) begin
        if (intact) word_end[walk_node] = 1'b1;
        res.found = intact;
      end else if (it.op == OP_WORD) begin
        res.found = intact && word_end[walk_node];
      end else begin
        res.found = intact;
      end
      res.exhausted = walk_overflow;
      expected_lookups.push_back(res);
      walk_node = 0;
      walk_broken = 0;
      walk_overflow = 0;
    end
  endtask

  task automatic queue_letter(input logic [OP_W-1:0] o, input logic [LETTER_W-1:0] l,
                              input bit lst, input bit drn);
    letter_item_t it;
    it.op = o;
    it.letter = l;
    it.last = lst;
    it.drain = drn;
    pending_items.push_back(it);
    item_count = item_count + 1;
  endtask

  task automatic queue_word(input logic [OP_W-1:0] wop, input int len, input bit drn,
                            input bit noisy);
    logic [OP_W-1:0] o;
    for (int i = 0; i < len; i++) begin
      o = noisy ? OP_W'($urandom_range(0, 3)) : wop;
      queue_letter(o, word_buf[i], i == len - 1, drn && i == 0);
    end
  endtask

  task automatic queue_direct(input logic [OP_W-1:0] wop, input int l0, input int l1,
                              input int len);
    word_buf[0] = LETTER_W'(l0);
    word_buf[1] = LETTER_W'(l1);
    queue_word(wop, len, 1'b0, 1'b0);
  endtask

  task automatic save_word(input int len);
    int idx;
    idx = (saved_count < SAVED_MAX) ? saved_count : $urandom_range(0, SAVED_MAX - 1);
    if (saved_count < SAVED_MAX) saved_count = saved_count + 1;
    for (int i = 0; i < len; i++) saved_letters[idx*WORD_MAX + i] = word_buf[i];
    saved_len[idx] = len;
  endtask

  task automatic build_word(input int letter_top, input int min_len, input int max_len,
                            output int len);
    len = $urandom_range(min_len, max_len);
    for (int i = 0; i < len; i++) word_buf[i] = LETTER_W'($urandom_range(0, letter_top));
  endtask

  task automatic queue_random_word(input int letter_top, input int max_len);
    int len;
    int pick;
    int idx;
    int r;
    logic [OP_W-1:0] wop;
    bit drn;
    drn = ($urandom_range(0, 24) == 0);
    if ($urandom_range(0, 99) < 15) begin
      // Malformed word: any letter code and a fresh op on every letter.
      build_word(31, 1, 4, len);
      queue_word(OP_INSERT, len, drn, 1'b1);
    end else begin
      r = $urandom_range(0, 9);
      wop = (r < 4) ? OP_INSERT : (r < 7) ? OP_WORD : (r < 9) ? OP_PREFIX : OP_SPARE;
      pick = $urandom_range(0, 1);
      if (pick == 1 && saved_count > 0) begin
        idx = $urandom_range(0, saved_count - 1);
        len = saved_len[idx];
        // A query on a stored word is cut short now and then.
        if (wop != OP_INSERT && $urandom_range(0, 3) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) word_buf[i] = saved_letters[idx*WORD_MAX + i];
      end else begin
        build_word(letter_top, 1, max_len, len);
      end
      queue_word(wop, len, drn, 1'b0);
      if (wop == OP_INSERT) save_word(len);
    end
  endtask

  // Driver: presents the next letter after a random pause, holds it until
  // the transfer, and feeds the model with every transferred letter.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
      calm = 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        trie_predict_step(cur_item);
        next_start = 1'b0;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        idle_left = calm ? 0 : $urandom_range(0, 8);
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && (expected_lookups.size() != 0 || done))) begin
          cur_item = pending_items.pop_front();
          op <= cur_item.op;
          letter <= cur_item.letter;
          last_letter <= cur_item.last;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every done pulse is checked against the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && done) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("result with no pending word");
      end else begin
        want = expected_lookups.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", found, want.found));
        if (pool_exhausted !== want.exhausted)
          report_mismatch($sformatf("pool_exhausted %b, expected %b",
                                    pool_exhausted, want.exhausted));
      end
    end
  end

  initial begin
    int len;
    trie_clear();

    // Directed words on an empty trie first.
    queue_direct(OP_WORD, 0, 1, 2);
    queue_direct(OP_PREFIX, 0, 0, 1);
    queue_direct(OP_INSERT, 0, 1, 2);
    queue_direct(OP_WORD, 0, 1, 2);
    queue_direct(OP_WORD, 0, 0, 1);
    queue_direct(OP_PREFIX, 0, 0, 1);
    queue_direct(OP_SPARE, 0, 0, 1);
    queue_direct(OP_INSERT, 25, 0, 1);
    queue_direct(OP_WORD, 25, 0, 1);
    queue_direct(OP_INSERT, 31, 0, 2);
    queue_direct(OP_SPARE, 31, 0, 1);
    queue_direct(OP_WORD, 0, 26, 2);
    queue_letter(OP_INSERT, 2, 1'b0, 1'b0);
    queue_letter(OP_WORD, 3, 1'b1, 1'b0);
    queue_letter(OP_WORD, 0, 1'b0, 1'b0);
    queue_letter(OP_INSERT, 4, 1'b1, 1'b0);

    // Small alphabet, so that queries often hit stored words.
    while (item_count < 700) queue_random_word(3, 5);

    // Long inserts over the full alphabet use up the node pool.
    for (int w = 0; w < 35; w++) begin
      build_word(25, 8, WORD_MAX, len);
      queue_word(OP_INSERT, len, w == 0, 1'b0);
      save_word(len);
    end

    while (item_count < 1225) queue_random_word(25, 6);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_lookups.size() != 0 || pending_items.size() != 0 || start)
      report_mismatch("results missing at the end of the run");
    if (mismatches == 0) begin
      $display("** trie_insert_and_lookup: PASSED **");
    end else begin
      $display("** trie_insert_and_lookup: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** trie_insert_and_lookup: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/trie_pkg.sv
rtl/core/trie_ram.sv
rtl/core/trie_ctrl.sv
rtl/core/trie_insert_and_lookup.sv
tb/tb.sv
